FILE: rtl/pwmt_pkg.sv
package pwmt_pkg;

  // Field and storage widths.
  localparam int unsigned CntWidth     = 16;
  localparam int unsigned PscWidth     = 16;
  localparam int unsigned ChannelCount = 4;
  localparam int unsigned PwmWidth     = 4;
  localparam int unsigned ChanIdxWidth = 2;
  localparam int unsigned DutyWidth    = 8;
  localparam int unsigned DutyMagWidth = DutyWidth - 1;
  localparam int unsigned DutyFull     = 100;

  // Scaling: compare = floor(auto_reload * duty / 100).
  // The product fits in ProdWidth bits; the division by 100 is a multiply by
  // ceil(2^RecipShift / 100) followed by a shift, exact over the whole range.
  localparam int unsigned ProdWidth  = CntWidth + DutyMagWidth;
  localparam int unsigned RecipShift = ProdWidth + DutyMagWidth;
  localparam int unsigned RecipWidth = 24;
  localparam logic [RecipWidth-1:0] RecipMult =
      RecipWidth'(((64'd1 << RecipShift) + 64'(DutyFull) - 64'd1) / 64'(DutyFull));
  localparam int unsigned ScaledWidth = ProdWidth + RecipWidth;

  // Register port geometry.
  localparam int unsigned ApbAddrWidth = 5;
  localparam int unsigned ApbDataWidth = 32;
  localparam int unsigned RegIdxWidth  = 3;

  // Input commands.
  typedef enum logic [1:0] {
    CmdTick      = 2'd0,
    CmdSetDuty   = 2'd1,
    CmdClearFlag = 2'd2,
    CmdNop       = 2'd3
  } cmd_e;

  // Register indexes (byte address is four times the index).
  typedef enum logic [RegIdxWidth-1:0] {
    RegPrescale   = 3'd0,
    RegAutoReload = 3'd1,
    RegCounterEn  = 3'd2,
    RegIrqEn      = 3'd3,
    RegChannelEn  = 3'd4,
    RegMainOutEn  = 3'd5
  } reg_idx_e;

  // Configuration as seen by the datapath.
  typedef struct packed {
    logic [PscWidth-1:0] psc;
    logic [CntWidth-1:0] auto_reload;
    logic                cnt_en;
    logic                irq_en;
    logic [PwmWidth-1:0] ch_en;
    logic                moe;
  } cfg_t;

endpackage

FILE: rtl/pwmt_regs.sv
module pwmt_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [pwmt_pkg::ApbAddrWidth-1:0]    paddr,
  input  logic [pwmt_pkg::ApbDataWidth-1:0]    pwdata,
  output logic [pwmt_pkg::ApbDataWidth-1:0]    prdata,
  output logic                                 pready,
  output pwmt_pkg::cfg_t                       cfg_o
);
  import pwmt_pkg::*;

  localparam cfg_t CfgReset = '{
    psc:         '0,
    auto_reload: '1,
    cnt_en:      1'b0,
    irq_en:      1'b0,
    ch_en:       '0,
    moe:         1'b0
  };

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[ApbAddrWidth-1:2]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  // Register write decode; writes outside the map are dropped.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        RegPrescale:   cfg_d.psc         = pwdata[PscWidth-1:0];
        RegAutoReload: cfg_d.auto_reload = pwdata[CntWidth-1:0];
        RegCounterEn:  cfg_d.cnt_en      = pwdata[0];
        RegIrqEn:      cfg_d.irq_en      = pwdata[0];
        RegChannelEn:  cfg_d.ch_en       = pwdata[PwmWidth-1:0];
        RegMainOutEn:  cfg_d.moe         = pwdata[0];
        default: ;
      endcase
    end
  end

  // Read data mux.
  always_comb begin
    case (idx)
      RegPrescale:   prdata = ApbDataWidth'(cfg_q.psc);
      RegAutoReload: prdata = ApbDataWidth'(cfg_q.auto_reload);
      RegCounterEn:  prdata = ApbDataWidth'(cfg_q.cnt_en);
      RegIrqEn:      prdata = ApbDataWidth'(cfg_q.irq_en);
      RegChannelEn:  prdata = ApbDataWidth'(cfg_q.ch_en);
      RegMainOutEn:  prdata = ApbDataWidth'(cfg_q.moe);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

FILE: rtl/pwmt_counter.sv
module pwmt_counter (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  pwmt_pkg::cfg_t                  cfg_i,
  input  logic                            step_i,
  input  logic                            clear_i,
  output logic [pwmt_pkg::CntWidth-1:0]   count_d_o,
  output logic                            flag_d_o
);
  import pwmt_pkg::*;

  logic [PscWidth-1:0] psc_q, psc_d;
  logic [CntWidth-1:0] cnt_q, cnt_d;
  logic                flag_q, flag_d;
  logic                psc_wrap;

  assign psc_wrap = psc_q >= cfg_i.psc;

  // Prescaler and main counter; a value at or above its top restarts at zero.
  always_comb begin
    psc_d  = psc_q;
    cnt_d  = cnt_q;
    flag_d = flag_q;
    if (step_i && cfg_i.cnt_en) begin
      if (psc_wrap) begin
        psc_d = '0;
        if (cnt_q >= cfg_i.auto_reload) begin
          cnt_d  = '0;
          flag_d = 1'b1;
        end else begin
          cnt_d = cnt_q + CntWidth'(1);
        end
      end else begin
        psc_d = psc_q + PscWidth'(1);
      end
    end
    if (clear_i) begin
      flag_d = 1'b0;
    end
  end

  assign count_d_o = cnt_d;
  assign flag_d_o  = flag_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      psc_q  <= '0;
      cnt_q  <= '0;
      flag_q <= 1'b0;
    end else begin
      psc_q  <= psc_d;
      cnt_q  <= cnt_d;
      flag_q <= flag_d;
    end
  end

  // A counter step always lands at or below the top value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && cfg_i.cnt_en && psc_wrap) |=> (cnt_q <= $past(cfg_i.auto_reload)))
    else $error("main counter stepped above auto reload");

  // The update flag is only raised by an enabled tick.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(flag_q) |-> $past(step_i && cfg_i.cnt_en))
    else $error("update flag set without a counting tick");

endmodule

FILE: rtl/pwmt_scale.sv
module pwmt_scale (
  input  logic                                clk_i,
  input  logic                                load_i,
  input  logic [pwmt_pkg::CntWidth-1:0]       auto_reload_i,
  input  logic [pwmt_pkg::DutyMagWidth-1:0]   duty_i,
  input  logic                                adv_i,
  output logic [pwmt_pkg::CntWidth-1:0]       quot_o
);
  import pwmt_pkg::*;

  logic [ProdWidth-1:0]   prod_q, prod_d;
  logic [ScaledWidth-1:0] scaled;
  logic [CntWidth-1:0]    quot_q, quot_d;

  // First stage: auto_reload times duty.
  assign prod_d = ProdWidth'(auto_reload_i) * ProdWidth'(duty_i);

  // Second stage: divide by 100 through the reciprocal multiply.
  assign scaled = ScaledWidth'(prod_q) * ScaledWidth'(RecipMult);
  assign quot_d = scaled[RecipShift +: CntWidth];

  assign quot_o = quot_q;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      prod_q <= prod_d;
    end
    if (adv_i) begin
      quot_q <= quot_d;
    end
  end

endmodule

FILE: rtl/pwmt_compare.sv
module pwmt_compare (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  pwmt_pkg::cfg_t                       cfg_i,
  input  logic                                 wr_i,
  input  logic [pwmt_pkg::ChanIdxWidth-1:0]    ch_i,
  input  logic [pwmt_pkg::CntWidth-1:0]        val_i,
  input  logic [pwmt_pkg::CntWidth-1:0]        count_i,
  output logic [pwmt_pkg::PwmWidth-1:0]        pwm_o
);
  import pwmt_pkg::*;

  logic [CntWidth-1:0] cmp_q [ChannelCount];
  logic                ch_hit;

  assign ch_hit = 32'(ch_i) < ChannelCount;

  // PWM mode 1: high while the count is below the compare value and both the channel
  // enable and main output enable are set. A compare written by this same transfer is forwarded.
  always_comb begin
    logic [CntWidth-1:0] eff;
    pwm_o = '0;
    for (int k = 0; k < ChannelCount; k++) begin
      eff = (wr_i && ch_i == ChanIdxWidth'(k)) ? val_i : cmp_q[k];
      pwm_o[k] = cfg_i.moe && cfg_i.ch_en[k] && (count_i < eff);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < ChannelCount; k++) begin
        cmp_q[k] <= '0;
      end
    end else if (wr_i && ch_hit) begin
      cmp_q[ch_i] <= val_i;
    end
  end

endmodule

FILE: rtl/pwm_timer_with_update_irq_top.sv
// Channel   Direction  Handshake               Payload
// input     in         in_valid_i/in_ready_o   command_i, channel_i, duty_percent_i
// result    out        out_valid_o/out_ready_i pwm_out_o, update_flag_o, irq_request_o,
//                                              count_value_o, duty_rejected_o
// config    in         psel/penable/pready     paddr, pwdata, prdata (APB, 32 bits)
//
// One item per cycle sustained while out_ready_i stays high.
// The four stages are the input register, the counter and duty-product stage, the
// reciprocal multiply that divides by 100, and the result register.
// Reset clears the counters, the update flag, the compare values and the pipeline.
// Each stage advances when the next one is empty or emptying, so a stalled result
// holds while upstream stages fill; in_ready_o drops once all four are full.
module pwm_timer_with_update_irq_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  command_i,
  input  logic [1:0]  channel_i,
  input  logic signed [7:0] duty_percent_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [3:0]  pwm_out_o,
  output logic        update_flag_o,
  output logic        irq_request_o,
  output logic [15:0] count_value_o,
  output logic        duty_rejected_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import pwmt_pkg::*;

  cfg_t cfg;

  // Stage valid bits and handshake chain.
  logic v0_q, v0_d, v1_q, v1_d, v2_q, v2_d, v3_q, v3_d;
  logic rdy1, rdy2, rdy3;
  logic load0, move0, move1, move2, move3;

  // Stage payloads.
  cmd_e                    cmd0_q;
  logic [ChanIdxWidth-1:0] ch0_q, ch1_q, ch2_q;
  logic signed [DutyWidth-1:0] duty0_q;
  logic [CntWidth-1:0]     cnt1_q, cnt2_q, cnt3_q;
  logic                    flag1_q, flag2_q, flag3_q;
  logic                    rej1_q, rej2_q, rej3_q;
  logic                    wr1_q, wr2_q;
  logic [PwmWidth-1:0]     pwm3_q;
  logic                    irq3_q;

  logic [CntWidth-1:0]     count_d;
  logic                    flag_d;
  logic [CntWidth-1:0]     quot;
  logic [PwmWidth-1:0]     pwm_d;
  logic                    is_set, duty_bad;

  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = !v0_q || rdy1;

  assign load0 = in_valid_i && in_ready_o;
  assign move0 = v0_q && rdy1;
  assign move1 = v1_q && rdy2;
  assign move2 = v2_q && rdy3;
  assign move3 = v3_q && out_ready_i;

  always_comb begin
    v0_d = load0 ? 1'b1 : (move0 ? 1'b0 : v0_q);
    v1_d = move0 ? 1'b1 : (move1 ? 1'b0 : v1_q);
    v2_d = move1 ? 1'b1 : (move2 ? 1'b0 : v2_q);
    v3_d = move2 ? 1'b1 : (move3 ? 1'b0 : v3_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= v0_d;
      v1_q <= v1_d;
      v2_q <= v2_d;
      v3_q <= v3_d;
    end
  end

  // Duty range check: only 0 to 100 percent is taken.
  assign is_set   = cmd0_q == CmdSetDuty;
  assign duty_bad = duty0_q[DutyWidth-1] || (duty0_q[DutyMagWidth-1:0] > DutyMagWidth'(DutyFull));

  pwmt_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  pwmt_counter u_counter (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .step_i    (move0 && cmd0_q == CmdTick),
    .clear_i   (move0 && cmd0_q == CmdClearFlag),
    .count_d_o (count_d),
    .flag_d_o  (flag_d)
  );

  pwmt_scale u_scale (
    .clk_i         (clk_i),
    .load_i        (move0),
    .auto_reload_i (cfg.auto_reload),
    .duty_i        (duty0_q[DutyMagWidth-1:0]),
    .adv_i         (move1),
    .quot_o        (quot)
  );

  pwmt_compare u_compare (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .wr_i    (move2 && wr2_q),
    .ch_i    (ch2_q),
    .val_i   (quot),
    .count_i (cnt2_q),
    .pwm_o   (pwm_d)
  );

  // Pipeline payload registers.
  always_ff @(posedge clk_i) begin
    if (load0) begin
      cmd0_q  <= cmd_e'(command_i);
      ch0_q   <= channel_i;
      duty0_q <= duty_percent_i;
    end
    if (move0) begin
      cnt1_q  <= count_d;
      flag1_q <= flag_d;
      rej1_q  <= is_set && duty_bad;
      wr1_q   <= is_set && !duty_bad;
      ch1_q   <= ch0_q;
    end
    if (move1) begin
      cnt2_q  <= cnt1_q;
      flag2_q <= flag1_q;
      rej2_q  <= rej1_q;
      wr2_q   <= wr1_q;
      ch2_q   <= ch1_q;
    end
    if (move2) begin
      cnt3_q  <= cnt2_q;
      flag3_q <= flag2_q;
      irq3_q  <= flag2_q && cfg.irq_en;
      rej3_q  <= rej2_q;
      pwm3_q  <= pwm_d;
    end
  end

  assign out_valid_o     = v3_q;
  assign pwm_out_o       = pwm3_q;
  assign update_flag_o   = flag3_q;
  assign irq_request_o   = irq3_q;
  assign count_value_o   = cnt3_q;
  assign duty_rejected_o = rej3_q;

  // Input back-pressure only when every stage holds a transfer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (v0_q && v1_q && v2_q && v3_q))
    else $error("input stalled with an empty pipeline stage");

endmodule
